>>> design/wrem_pkg.sv
package wrem_pkg;

    localparam int POS_W      = 48;
    localparam int TIME_W     = 48;
    localparam int RATE_W     = 56;
    localparam int MIN_W      = 20;
    localparam int SEC_W      = 6;
    localparam int NUM_W      = 58;   // position change times 1000
    localparam int DIV_W      = 64;
    localparam int STEP_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam int MS_PER_S     = 1000;
    localparam int SECS_PER_MIN = 60;
    localparam int SECTOR_SHIFT = 9;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_TOTAL_SIZE   = 2'd0;
    localparam t_cfg_index CFG_SECTOR_UNITS = 2'd1;

    localparam logic [RATE_W-1:0] RATE_MAX = '1;
    localparam logic [MIN_W-1:0]  MIN_MAX  = '1;
    localparam logic [NUM_W-1:0]  SECTOR_RAW_MAX = NUM_W'(RATE_MAX >> SECTOR_SHIFT);

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

endpackage

>>> design/windowed_rate_and_eta_meter_core.sv
// Sliding-window rate and remaining-time meter.
// Input channel: one progress sample per word (position, timestamp in ms),
// valid/stall handshake; o_in_stall is high while a sample is in work.
// Output channel: one result word per sample (rate per second, estimate
// flag, minutes, seconds), valid/stall handshake from an output register.
// Configuration: write total_size (index 0) and sector_units (index 1)
// through the write port while the block is idle.
// Samples live in a window memory of WINDOW_SLOTS entries; the oldest entry
// is read in the cycle of the write and used in the next cycle.
// The result word is built through up to three divisions (58, 48 and 48
// quotient bits) in one shared divider at one bit per cycle: none when
// there is nothing to divide and only the first when the rate itself comes
// out zero. The next sample is taken the cycle after the result is loaded,
// so only one sample is in work at a time.
// Reset clears the window (empty), both registers and the output valid.
// While the receiver stalls, the result word holds; a finished second
// result waits inside until the output register frees.
module windowed_rate_and_eta_meter_core #(
    parameter int WINDOW_SLOTS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  wrem_pkg::t_cfg_index                 i_cfg_index,
    input  logic [wrem_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [wrem_pkg::POS_W-1:0]           i_position,
    input  logic [wrem_pkg::TIME_W-1:0]          i_time_ms,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [wrem_pkg::RATE_W-1:0]          o_rate_per_second,
    output logic                                 o_eta_valid,
    output logic [wrem_pkg::MIN_W-1:0]           o_eta_minutes,
    output logic [wrem_pkg::SEC_W-1:0]           o_eta_seconds
);

    localparam int IDXW  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int CNTW  = $clog2(WINDOW_SLOTS + 1);
    localparam int MEM_W = wrem_pkg::POS_W + wrem_pkg::TIME_W;
    localparam logic [CNTW-1:0] SLOTS_C   = CNTW'(WINDOW_SLOTS);
    localparam logic [IDXW:0]   SLOTS_X   = (IDXW+1)'(WINDOW_SLOTS);
    localparam logic [IDXW-1:0] LAST_SLOT = IDXW'(WINDOW_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_RATE_DIV,
        ST_ETA,
        ST_MIN_DIV,
        ST_SECS_DIV,
        ST_DONE
    } t_state;

    t_state                             r_state;
    logic [IDXW-1:0]                    r_oldest;
    logic [CNTW-1:0]                    r_count;
    logic [wrem_pkg::POS_W-1:0]         r_total;
    logic                               r_sector;

    logic [MEM_W-1:0]                   r_mem [WINDOW_SLOTS];
    logic [MEM_W-1:0]                   r_rd_data;

    logic [wrem_pkg::POS_W-1:0]         r_pos;
    logic [wrem_pkg::TIME_W-1:0]        r_time;
    logic                               r_two;
    logic [wrem_pkg::TIME_W-1:0]        r_dt;
    logic                               r_dt_ok;
    logic [wrem_pkg::POS_W-1:0]         r_dp;
    logic [wrem_pkg::POS_W-1:0]         r_target;
    logic [wrem_pkg::NUM_W-1:0]         r_raw;
    logic [wrem_pkg::RATE_W-1:0]        r_rate;
    logic                               r_eta_ok;
    logic [wrem_pkg::MIN_W-1:0]         r_mins;
    logic [wrem_pkg::SEC_W-1:0]         r_secs;

    logic                               r_out_valid;
    logic [wrem_pkg::RATE_W-1:0]        r_out_rate;
    logic                               r_out_eta_valid;
    logic [wrem_pkg::MIN_W-1:0]         r_out_mins;
    logic [wrem_pkg::SEC_W-1:0]         r_out_secs;

    wrem_pkg::t_div_req                 r_div_req;
    wrem_pkg::t_div_rsp                 div_rsp;

    logic                               n_accept;
    logic                               n_full;
    logic [IDXW:0]                      n_sum;
    logic [IDXW-1:0]                    n_tail;
    logic [IDXW-1:0]                    n_next_oldest;
    logic [IDXW-1:0]                    n_wslot;
    logic [IDXW-1:0]                    n_rslot;
    logic [wrem_pkg::POS_W-1:0]         n_old_pos;
    logic [wrem_pkg::TIME_W-1:0]        n_old_time;
    logic [wrem_pkg::NUM_W-1:0]         n_num;
    logic [wrem_pkg::RATE_W-1:0]        n_rate;
    logic [wrem_pkg::POS_W-1:0]         n_remain;
    logic [wrem_pkg::DIV_W-1:0]         n_raw60;
    logic                               n_div_start;
    logic                               n_out_load;

    always_comb begin
        n_accept      = i_in_valid && (r_state == ST_IDLE);
        n_full        = (r_count == SLOTS_C);
        n_sum         = {1'b0, r_oldest} + {1'b0, r_count[IDXW-1:0]};
        n_tail        = (n_sum >= SLOTS_X) ? IDXW'(n_sum - SLOTS_X) : n_sum[IDXW-1:0];
        n_next_oldest = (r_oldest == LAST_SLOT) ? '0 : r_oldest + 1'b1;
        // a full window overwrites its oldest entry; the next one becomes oldest
        n_wslot       = n_full ? r_oldest : n_tail;
        n_rslot       = n_full ? n_next_oldest : r_oldest;

        n_old_pos  = r_rd_data[MEM_W-1:wrem_pkg::TIME_W];
        n_old_time = r_rd_data[wrem_pkg::TIME_W-1:0];
        n_num      = wrem_pkg::NUM_W'(r_dp) * wrem_pkg::NUM_W'(wrem_pkg::MS_PER_S);

        if (r_sector) begin
            n_rate = (r_raw > wrem_pkg::SECTOR_RAW_MAX) ? wrem_pkg::RATE_MAX
                   : wrem_pkg::RATE_W'(r_raw) << wrem_pkg::SECTOR_SHIFT;
        end else begin
            n_rate = (r_raw > wrem_pkg::NUM_W'(wrem_pkg::RATE_MAX)) ? wrem_pkg::RATE_MAX
                   : wrem_pkg::RATE_W'(r_raw);
        end
        n_remain = (r_target > r_pos) ? r_target - r_pos : '0;
        // rate times 60 as times 64 minus times 4; below 2^64 since the rate is below 2^58
        n_raw60  = (wrem_pkg::DIV_W'(r_raw) << 6) - (wrem_pkg::DIV_W'(r_raw) << 2);

        n_div_start = ((r_state == ST_MUL) && r_dt_ok && (r_dp != '0))
                   || ((r_state == ST_ETA) && (r_raw != '0))
                   || ((r_state == ST_MIN_DIV) && div_rsp.done);
        n_out_load  = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // window memory: write the new sample, read the oldest in the same cycle
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_mem[n_wslot] <= {i_position, i_time_ms};
            r_rd_data      <= r_mem[n_rslot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_oldest        <= '0;
            r_count         <= '0;
            r_total         <= '0;
            r_sector        <= 1'b0;
            r_out_valid     <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= n_div_start;
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    wrem_pkg::CFG_TOTAL_SIZE:   r_total  <= i_cfg_data;
                    wrem_pkg::CFG_SECTOR_UNITS: r_sector <= i_cfg_data[0];
                    default: ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_pos    <= i_position;
                        r_time   <= i_time_ms;
                        r_two    <= n_full || (r_count != '0);
                        r_oldest <= n_full ? n_next_oldest : r_oldest;
                        r_count  <= n_full ? r_count : r_count + 1'b1;
                        r_state  <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_dt     <= r_time - n_old_time;
                    r_dt_ok  <= r_two && (r_time > n_old_time);
                    r_dp     <= (r_pos > n_old_pos) ? r_pos - n_old_pos : '0;
                    r_target <= r_sector
                              ? (wrem_pkg::POS_W'(r_total >> wrem_pkg::SECTOR_SHIFT)
                                 + wrem_pkg::POS_W'(r_total[wrem_pkg::SECTOR_SHIFT-1:0] != '0))
                              : r_total;
                    r_state  <= ST_MUL;
                end
                ST_MUL: begin
                    if (r_dt_ok && (r_dp != '0)) begin
                        r_div_req.steps    <= wrem_pkg::STEP_W'(wrem_pkg::NUM_W);
                        r_div_req.dividend <= {n_num,
                                               {(wrem_pkg::DIV_W-wrem_pkg::NUM_W){1'b0}}};
                        r_div_req.divisor  <= wrem_pkg::DIV_W'(r_dt);
                        r_state            <= ST_RATE_DIV;
                    end else begin
                        r_raw   <= '0;
                        r_state <= ST_ETA;
                    end
                end
                ST_RATE_DIV: begin
                    if (div_rsp.done) begin
                        r_raw   <= div_rsp.quot[wrem_pkg::NUM_W-1:0];
                        r_state <= ST_ETA;
                    end
                end
                ST_ETA: begin
                    r_rate <= n_rate;
                    if (r_raw == '0) begin
                        r_eta_ok <= 1'b0;
                        r_mins   <= '0;
                        r_secs   <= '0;
                        r_state  <= ST_DONE;
                    end else begin
                        // whole minutes first: remaining count over 60 times the rate
                        r_eta_ok           <= 1'b1;
                        r_div_req.steps    <= wrem_pkg::STEP_W'(wrem_pkg::POS_W);
                        r_div_req.dividend <= {n_remain,
                                               {(wrem_pkg::DIV_W-wrem_pkg::POS_W){1'b0}}};
                        r_div_req.divisor  <= n_raw60;
                        r_state            <= ST_MIN_DIV;
                    end
                end
                ST_MIN_DIV: begin
                    // the remainder is at most the remaining count, so it fits in 48 bits;
                    // over the rate it gives the seconds past the whole minutes
                    if (div_rsp.done) begin
                        r_mins  <= (div_rsp.quot > wrem_pkg::DIV_W'(wrem_pkg::MIN_MAX))
                                 ? wrem_pkg::MIN_MAX : div_rsp.quot[wrem_pkg::MIN_W-1:0];
                        r_div_req.steps    <= wrem_pkg::STEP_W'(wrem_pkg::POS_W);
                        r_div_req.dividend <= {div_rsp.rem[wrem_pkg::POS_W-1:0],
                                               {(wrem_pkg::DIV_W-wrem_pkg::POS_W){1'b0}}};
                        r_div_req.divisor  <= wrem_pkg::DIV_W'(r_raw);
                        r_state            <= ST_SECS_DIV;
                    end
                end
                ST_SECS_DIV: begin
                    if (div_rsp.done) begin
                        r_secs  <= div_rsp.quot[wrem_pkg::SEC_W-1:0];
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (n_out_load) begin
                        r_out_rate      <= r_rate;
                        r_out_eta_valid <= r_eta_ok;
                        r_out_mins      <= r_mins;
                        r_out_secs      <= r_secs;
                        r_state         <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    wrem_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    assign o_out_valid       = r_out_valid;
    assign o_rate_per_second = r_out_rate;
    assign o_eta_valid       = r_out_eta_valid;
    assign o_eta_minutes     = r_out_mins;
    assign o_eta_seconds     = r_out_secs;

endmodule

>>> design/wrem_divider.sv
module wrem_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wrem_pkg::t_div_req i_req,
    output wrem_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [wrem_pkg::STEP_W-1:0]   r_cnt;
    logic [wrem_pkg::DIV_W-1:0]    r_rem;
    logic [wrem_pkg::DIV_W-1:0]    r_quo;
    logic [wrem_pkg::DIV_W-1:0]    r_dvs;

    logic [wrem_pkg::DIV_W:0]      n_rem_sh;
    logic [wrem_pkg::DIV_W:0]      n_rem_sub;
    logic                          n_ge;

    // one quotient bit per cycle; the dividend arrives left-aligned so only
    // its significant bits are stepped through
    always_comb begin
        n_rem_sh  = {r_rem, r_quo[wrem_pkg::DIV_W-1]};
        n_ge      = n_rem_sh >= {1'b0, r_dvs};
        n_rem_sub = n_rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == wrem_pkg::STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_rem_sub[wrem_pkg::DIV_W-1:0]
                              : n_rem_sh[wrem_pkg::DIV_W-1:0];
                r_quo <= {r_quo[wrem_pkg::DIV_W-2:0], n_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == wrem_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

>>> design/wrem_checker.sv
module wrem_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [wrem_pkg::RATE_W-1:0]      o_rate_per_second,
    input logic                             o_eta_valid,
    input logic [wrem_pkg::MIN_W-1:0]       o_eta_minutes,
    input logic [wrem_pkg::SEC_W-1:0]       o_eta_seconds
);

    // a taken sample closes the input until its result is done
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after a sample was taken");

    // no estimate means the rate was zero and the time fields are clear
    a_no_eta_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_eta_valid) |->
            (o_rate_per_second == '0) && (o_eta_minutes == '0) && (o_eta_seconds == '0))
        else $error("result without estimate carries nonzero fields");

    a_secs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_eta_seconds < wrem_pkg::SEC_W'(wrem_pkg::SECS_PER_MIN)))
        else $error("seconds field out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            o_out_valid && $stable(o_rate_per_second) && $stable(o_eta_valid)
            && $stable(o_eta_minutes) && $stable(o_eta_seconds))
        else $error("stalled result word changed");

endmodule

bind windowed_rate_and_eta_meter_core wrem_checker u_wrem_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_rate_per_second (o_rate_per_second),
    .o_eta_valid       (o_eta_valid),
    .o_eta_minutes     (o_eta_minutes),
    .o_eta_seconds     (o_eta_seconds)
);

>>> tb/tb_windowed_rate_and_eta_meter_core.sv
`timescale 1ns / 100ps

module tb_windowed_rate_and_eta_meter_core;

    localparam int          WINDOW_SLOTS = 16;
    localparam int unsigned LONG_HOLD    = 1000;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned STREAM_ITEMS = 112;

    // indexes past the last register; writes there must change nothing
    localparam wrem_pkg::t_cfg_index CFG_SPARE_2 = 2'd2;
    localparam wrem_pkg::t_cfg_index CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [wrem_pkg::RATE_W-1:0] rate;
        logic                        eta_valid;
        logic [wrem_pkg::MIN_W-1:0]  minutes;
        logic [wrem_pkg::SEC_W-1:0]  seconds;
    } t_meter_word;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    wrem_pkg::t_cfg_index            cfg_index = wrem_pkg::CFG_TOTAL_SIZE;
    logic [wrem_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic [wrem_pkg::POS_W-1:0]      position  = '0;
    logic [wrem_pkg::TIME_W-1:0]     time_ms   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [wrem_pkg::RATE_W-1:0]     rate_per_second;
    logic                            eta_valid;
    logic [wrem_pkg::MIN_W-1:0]      eta_minutes;
    logic [wrem_pkg::SEC_W-1:0]      eta_seconds;

    // predictor state: sample window and register copies
    logic [wrem_pkg::POS_W-1:0]  win_pos  [WINDOW_SLOTS];
    logic [wrem_pkg::TIME_W-1:0] win_time [WINDOW_SLOTS];
    int unsigned                 win_head    = 0;
    int unsigned                 win_fill    = 0;
    logic [wrem_pkg::POS_W-1:0]  total_bytes = '0;
    logic                        sector_mode = 1'b0;

    t_meter_word expected_meter_q[$];

    int unsigned                 mismatch_count   = 0;
    int unsigned                 cycle_count      = 0;
    int unsigned                 stall_left       = 0;
    int unsigned                 hold_req_count   = 0;
    int unsigned                 hold_seen_count  = 0;
    logic                        no_input_gaps    = 1'b0;
    logic                        no_output_stalls = 1'b0;
    logic [wrem_pkg::POS_W-1:0]  stream_pos       = '0;
    logic [wrem_pkg::TIME_W-1:0] stream_time      = '0;

    windowed_rate_and_eta_meter_core #(
        .WINDOW_SLOTS(WINDOW_SLOTS)
    ) DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_position       (position),
        .i_time_ms        (time_ms),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_rate_per_second(rate_per_second),
        .o_eta_valid      (eta_valid),
        .o_eta_minutes    (eta_minutes),
        .o_eta_seconds    (eta_seconds)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_meter_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // random value of random width, 1 to max_w bits
    function automatic logic [63:0] rand_bits(input int unsigned max_w);
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r >> (64 - $urandom_range(max_w, 1));
    endfunction

    // push one sample into the window and work out its result word
    function automatic t_meter_word predict_meter(input logic [wrem_pkg::POS_W-1:0]  pos,
                                                  input logic [wrem_pkg::TIME_W-1:0] t);
        t_meter_word res;
        int unsigned slot;
        int unsigned newest;
        logic [63:0] raw;
        logic [63:0] dpos;
        logic [63:0] dtime;
        logic [63:0] target;
        logic [63:0] remain;
        logic [63:0] secs;
        logic [63:0] mins;
        if (win_fill >= WINDOW_SLOTS) begin
            slot = win_head;
            win_head = (win_head + 1) % WINDOW_SLOTS;
        end else begin
            slot = (win_head + win_fill) % WINDOW_SLOTS;
            win_fill++;
        end
        win_pos[slot]  = pos;
        win_time[slot] = t;

        raw = '0;
        if (win_fill >= 2) begin
            newest = (win_head + win_fill - 1) % WINDOW_SLOTS;
            if (win_time[newest] > win_time[win_head]) begin
                dtime = 64'(win_time[newest]) - 64'(win_time[win_head]);
                dpos  = '0;
                if (win_pos[newest] > win_pos[win_head])
                    dpos = 64'(win_pos[newest]) - 64'(win_pos[win_head]);
                raw = (dpos * 64'(wrem_pkg::MS_PER_S)) / dtime;
            end
        end

        res = '0;
        if (sector_mode)
            res.rate = (raw > 64'(wrem_pkg::SECTOR_RAW_MAX)) ? wrem_pkg::RATE_MAX
                     : wrem_pkg::RATE_W'(raw << wrem_pkg::SECTOR_SHIFT);
        else
            res.rate = (raw > 64'(wrem_pkg::RATE_MAX)) ? wrem_pkg::RATE_MAX
                     : wrem_pkg::RATE_W'(raw);

        if (raw != 0) begin
            // round the target up to whole sectors
            if (sector_mode)
                target = (64'(total_bytes) >> wrem_pkg::SECTOR_SHIFT)
                         + 64'(total_bytes[wrem_pkg::SECTOR_SHIFT-1:0] != 0);
            else
                target = 64'(total_bytes);
            remain = (target > 64'(pos)) ? target - 64'(pos) : '0;
            secs   = remain / raw;
            mins   = secs / 64'(wrem_pkg::SECS_PER_MIN);
            res.eta_valid = 1'b1;
            res.minutes   = (mins > 64'(wrem_pkg::MIN_MAX)) ? wrem_pkg::MIN_MAX
                          : wrem_pkg::MIN_W'(mins);
            res.seconds   = wrem_pkg::SEC_W'(secs % 64'(wrem_pkg::SECS_PER_MIN));
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // receiver: random hold-off after every taken word, long hold on request
    always @(posedge clk) begin : out_stall_gen
        if (hold_req_count != hold_seen_count) begin
            hold_seen_count = hold_req_count;
            stall_left = LONG_HOLD;
        end else if (out_valid === 1'b1 && out_stall === 1'b0) begin
            stall_left = no_output_stalls ? 0 : $urandom_range(15);
        end else if (stall_left != 0) begin
            stall_left--;
        end
        out_stall <= (stall_left != 0);
    end

    always @(posedge clk) begin : result_check
        t_meter_word want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (expected_meter_q.size() == 0) begin
                report_mismatch("result word with none expected", 64'(rate_per_second),
                                64'(0));
            end else begin
                want = expected_meter_q[0];
                expected_meter_q.delete(0);
                if (rate_per_second !== want.rate)
                    report_mismatch("rate_per_second", 64'(rate_per_second), 64'(want.rate));
                if (eta_valid !== want.eta_valid)
                    report_mismatch("eta_valid", 64'(eta_valid), 64'(want.eta_valid));
                if (eta_minutes !== want.minutes)
                    report_mismatch("eta_minutes", 64'(eta_minutes), 64'(want.minutes));
                if (eta_seconds !== want.seconds)
                    report_mismatch("eta_seconds", 64'(eta_seconds), 64'(want.seconds));
            end
        end
    end

    task automatic send_sample(input logic [wrem_pkg::POS_W-1:0]  pos,
                               input logic [wrem_pkg::TIME_W-1:0] t);
        int unsigned gap;
        gap = no_input_gaps ? 0 : $urandom_range(15);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        position <= pos;
        time_ms  <= t;
        do @(posedge clk); while (in_stall);
        expected_meter_q.insert(expected_meter_q.size(), predict_meter(pos, t));
    endtask

    // hold the input until every expected word has come out
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_meter_q.size() != 0);
    endtask

    task automatic write_reg(input wrem_pkg::t_cfg_index idx,
                             input logic [wrem_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            wrem_pkg::CFG_TOTAL_SIZE:   total_bytes = data;
            wrem_pkg::CFG_SECTOR_UNITS: sector_mode = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // next sample of a progress stream, with the odd outlier
    task automatic send_stream_sample();
        logic [wrem_pkg::POS_W-1:0]  p;
        logic [wrem_pkg::TIME_W-1:0] t;
        case ($urandom_range(19))
            0, 1: begin
                p = wrem_pkg::POS_W'({$urandom(), $urandom()});
                t = wrem_pkg::TIME_W'({$urandom(), $urandom()});
            end
            2: begin
                p = stream_pos - wrem_pkg::POS_W'(rand_bits(16));
                t = stream_time + wrem_pkg::TIME_W'(rand_bits(10));
                stream_pos  = p;
                stream_time = t;
            end
            3: begin
                p = stream_pos + wrem_pkg::POS_W'(rand_bits(40));
                t = stream_time + wrem_pkg::TIME_W'(rand_bits(40));
                stream_pos  = p;
                stream_time = t;
            end
            default: begin
                p = stream_pos + wrem_pkg::POS_W'(rand_bits(32));
                t = stream_time + wrem_pkg::TIME_W'(rand_bits(12));
                stream_pos  = p;
                stream_time = t;
            end
        endcase
        send_sample(p, t);
    endtask

    // empty window, then a plain rate with the reset target
    task automatic test_window_startup();
        send_sample(48'd1000, 48'd1000);
        send_sample(48'd6000, 48'd2000);
    endtask

    task automatic test_register_writes();
        wait_results_drained();
        write_reg(wrem_pkg::CFG_TOTAL_SIZE, 48'd1000000);
        send_sample(48'd11000, 48'd3000);
        // target not a whole number of sectors
        wait_results_drained();
        write_reg(wrem_pkg::CFG_TOTAL_SIZE, 48'd25600007);
        write_reg(wrem_pkg::CFG_SECTOR_UNITS, 48'd1);
        send_sample(48'd21000, 48'd4000);
        wait_results_drained();
        write_reg(wrem_pkg::CFG_TOTAL_SIZE, 48'd25600000);
        send_sample(48'd31000, 48'd5000);
        // spare indexes, then extremes with junk above the mode bit
        wait_results_drained();
        write_reg(CFG_SPARE_2, '1);
        write_reg(CFG_SPARE_3, '1);
        write_reg(wrem_pkg::CFG_TOTAL_SIZE, '1);
        write_reg(wrem_pkg::CFG_SECTOR_UNITS, 48'hFFFF_FFFF_FFFE);
    endtask

    task automatic test_special_cases();
        send_sample(48'd1001, 48'd1001000);             // raw rate rounds to zero
        send_sample(48'd2000, 48'd1001);                // fast rate, long remaining time
        send_sample(48'd5000, 48'd1000);                // no time change
        send_sample(48'd5000, 48'd0);                   // time going back
        send_sample(48'd0, 48'd5000);                   // position going back
        send_sample(48'hFFFF_FFFF_FFFF, 48'd1001);      // saturated rate, at the target
        wait_results_drained();
        write_reg(wrem_pkg::CFG_SECTOR_UNITS, 48'd1);
        send_sample(48'hFFFF_FFFF_FFFF, 48'd1002);      // saturated sector rate
        wait_results_drained();
        write_reg(wrem_pkg::CFG_SECTOR_UNITS, 48'd0);
        send_sample(48'd2000, 48'd1001000);             // minutes saturate
        send_sample(48'd3000, 48'hFFFF_FFFF_FFFF);      // largest timestamp
        send_sample(48'd0, 48'd0);
    endtask

    // receiver holds off long while samples keep coming
    task automatic test_output_backpressure();
        wait_results_drained();
        stream_pos  = 48'd4096;
        stream_time = 48'd50000;
        hold_req_count <= hold_req_count + 1;
        no_input_gaps = 1'b1;
        repeat (8) send_stream_sample();
        no_input_gaps = 1'b0;
        wait_results_drained();
    endtask

    task automatic test_sender_pause();
        repeat (4) send_stream_sample();
        wait_results_drained();
        repeat (4) send_stream_sample();
    endtask

    task automatic test_random_streams();
        logic [wrem_pkg::CFG_DATA_W-1:0] tot;
        logic                            sect;
        for (int ph = 0; ph < 6; ph++) begin
            wait_results_drained();
            case (ph)
                0: begin
                    tot  = '1;
                    sect = 1'b0;
                end
                1: begin
                    tot  = '0;
                    sect = 1'b1;
                end
                5: begin
                    tot  = '1;
                    sect = 1'b1;
                end
                default: begin
                    tot  = $urandom_range(1)
                         ? wrem_pkg::CFG_DATA_W'({$urandom(), $urandom()})
                         : wrem_pkg::CFG_DATA_W'(rand_bits(48));
                    sect = 1'($urandom_range(1));
                end
            endcase
            no_input_gaps    = (ph == 2);
            no_output_stalls = (ph == 2);
            write_reg(wrem_pkg::CFG_TOTAL_SIZE, tot);
            write_reg(wrem_pkg::CFG_SECTOR_UNITS,
                      {(wrem_pkg::CFG_DATA_W-1)'(rand_bits(47)), sect});
            stream_pos  = wrem_pkg::POS_W'(rand_bits(36));
            stream_time = wrem_pkg::TIME_W'(rand_bits(47));
            repeat (STREAM_ITEMS) send_stream_sample();
        end
        no_input_gaps    = 1'b0;
        no_output_stalls = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_window_startup();
        test_register_writes();
        test_special_cases();
        test_output_backpressure();
        test_sender_pause();
        test_random_streams();
        wait_results_drained();
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && expected_meter_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
